// ===== design/mst_pkg.sv =====
// Shared constants, payload types and arithmetic helpers for the MLP trainer.
// Holds the sigmoid table, built at elaboration; no dependencies.
`timescale 1ns / 1ps

package mst_pkg;

  localparam int INPUTS       = 2;
  localparam int HIDDEN_UNITS = 4;
  localparam int SIG_DEPTH    = 256;

  localparam int STORE_DEPTH  = INPUTS * HIDDEN_UNITS + 2 * HIDDEN_UNITS + 1;
  localparam int HBIAS_BASE   = INPUTS * HIDDEN_UNITS;
  localparam int OWEIGHT_BASE = HBIAS_BASE + HIDDEN_UNITS;
  localparam int OBIAS_AT     = OWEIGHT_BASE + HIDDEN_UNITS;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int J_W    = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int K_W    = (INPUTS > 1) ? $clog2(INPUTS) : 1;
  localparam int SIG_W  = $clog2(SIG_DEPTH);

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_TRAIN = 2'd1;
  localparam logic [1:0] OP_INFER = 2'd2;

  localparam logic [12:0] LR_RESET = 13'd410;
  localparam logic [12:0] Q_ONE    = 13'd4096;
  localparam logic [12:0] Q_HALF   = 13'd2048;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [4:0]         param_index;
    logic signed [15:0] param_value;
    logic signed [15:0] sample_x0;
    logic signed [15:0] sample_x1;
    logic [12:0]        target;
  } in_item_t;

  typedef struct packed {
    logic [12:0] prediction;
    logic [12:0] squared_error;
    logic        correct;
  } out_item_t;

  typedef struct packed {
    logic               we;
    addr_t              addr;
    logic signed [15:0] wdata;
  } mem_req_t;

  typedef logic [12:0] sig_rom_t [SIG_DEPTH];

  // shift-subtract quotient, used only while building the table
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [12:0] rom_entry(input int k);
    longint num;
    longint xm;
    longint a;
    longint sum;
    longint e;
    longint s;
    longint den;
    longint one;
    longint unsigned g;
    longint unsigned term;
    one  = longint'(1) << 30;
    num  = (longint'(2 * k + 1) * longint'(524288)) >>> SIG_W;
    xm   = num - longint'(524288);
    a    = (xm < 0) ? -xm : xm;
    g    = longint'(a) << 11;
    term = 64'd1 << 30;
    sum  = one;
    for (int n = 1; n <= 20; n++) begin
      term = udiv64((term * g) >> 30, 64'(n));
      if ((n & 1) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    e = (sum < 0) ? longint'(0) : sum;
    if (e > one) e = one;
    for (int r = 0; r < 3; r++) begin
      e = longint'((longint'(e) * longint'(e)) >> 30);
    end
    den = one + e;
    s = longint'(udiv64(64'((longint'(1) << 42) + (den >>> 1)), 64'(den)));
    if (s > 4096) s = 4096;
    if (xm < 0) s = 4096 - s;
    return 13'(s);
  endfunction

  function automatic sig_rom_t sig_rom_init();
    sig_rom_t r;
    for (int k = 0; k < SIG_DEPTH; k++) begin
      r[k] = rom_entry(k);
    end
    return r;
  endfunction

  localparam sig_rom_t SIG_ROM = sig_rom_init();

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > 48'sd32767) r = 16'sh7fff;
    else if (v < -48'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic [12:0] sig_lookup(input logic signed [15:0] pre);
    logic [15:0] u;
    u = {~pre[15], pre[14:0]};
    return SIG_ROM[u[15 -: SIG_W]];
  endfunction

endpackage

// ===== design/mst_mul.sv =====
// Registered signed multiplier shared by every product of the trainer.
// Depends on nothing beyond its operand widths.
`timescale 1ns / 1ps

module mst_mul (
  input  logic               clk_i,
  input  logic signed [29:0] a_i,
  input  logic signed [15:0] b_i,
  output logic signed [45:0] p_o
);

  logic signed [45:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 46'(a_i) * 46'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== design/mst_wmem.sv =====
// Weight store: single-port synchronous RAM with a registered read port.
// Per-entry valid bits make unwritten entries read as zero; uses mst_pkg.
`timescale 1ns / 1ps

module mst_wmem (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mst_pkg::mem_req_t   req_i,
  output logic signed [15:0]  rdata_o
);

  logic signed [15:0]               mem_q [mst_pkg::STORE_DEPTH];
  logic [mst_pkg::STORE_DEPTH-1:0]  vld_q;
  logic signed [15:0]               rdata_q;
  logic                             rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      rvld_q <= vld_q[req_i.addr];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : 16'sd0;

endmodule

// ===== design/mlp_sgd_train_step.sv =====
// 2-4-1 sigmoid MLP with per-sample gradient descent around one RAM and one MAC.
// A load or unused code goes straight to the output register; infer and train first run
// the forward pass, and train then updates the weights after the result is issued. An
// item holds the input until done, set by the shared multiplier and the single weight
// RAM port, and longer while a waiting result blocks the output. One item at a time.
// Reset clears the weight store (valid bits), learning rate to 410, FSM to idle.
`timescale 1ns / 1ps

module mlp_sgd_train_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mst_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mst_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [12:0]        cfg_data_i
);

  localparam int NI = mst_pkg::INPUTS;
  localparam int HU = mst_pkg::HIDDEN_UNITS;
  localparam int AW = mst_pkg::ADDR_W;
  localparam int JW = mst_pkg::J_W;
  localparam int KW = mst_pkg::K_W;

  typedef enum logic [31:0] {
    S_IDLE = 32'd1 << 0,
    S_HBL  = 32'd1 << 1,
    S_HM   = 32'd1 << 2,
    S_HA   = 32'd1 << 3,
    S_HS   = 32'd1 << 4,
    S_OBL  = 32'd1 << 5,
    S_OM   = 32'd1 << 6,
    S_OA   = 32'd1 << 7,
    S_OS   = 32'd1 << 8,
    S_SQ   = 32'd1 << 9,
    S_SQA  = 32'd1 << 10,
    S_OUT  = 32'd1 << 11,
    S_DY   = 32'd1 << 12,
    S_DYA  = 32'd1 << 13,
    S_DO   = 32'd1 << 14,
    S_DOA  = 32'd1 << 15,
    S_HD1  = 32'd1 << 16,
    S_HD2  = 32'd1 << 17,
    S_HD3  = 32'd1 << 18,
    S_HD4  = 32'd1 << 19,
    S_HD5  = 32'd1 << 20,
    S_UW0  = 32'd1 << 21,
    S_UW1  = 32'd1 << 22,
    S_UW2  = 32'd1 << 23,
    S_UB0  = 32'd1 << 24,
    S_UB1  = 32'd1 << 25,
    S_VW0  = 32'd1 << 26,
    S_VW1  = 32'd1 << 27,
    S_VW2  = 32'd1 << 28,
    S_VB0  = 32'd1 << 29,
    S_VB1  = 32'd1 << 30
  } state_e;

  state_e state_q, state_d;
  logic [1:0]         op_q, op_d;
  logic signed [15:0] x_q [NI];
  logic signed [15:0] x_d [NI];
  logic [12:0]        hid_q [HU];
  logic [12:0]        hid_d [HU];
  logic signed [15:0] wo_q [HU];
  logic signed [15:0] wo_d [HU];
  logic signed [15:0] hd_q [HU];
  logic signed [15:0] hd_d [HU];
  logic [12:0]        t_q, t_d, y_q, y_d, sq_q, sq_d, lr_q, lr_d;
  logic               cor_q, cor_d;
  logic signed [13:0] err_q, err_d, err_new;
  logic [JW-1:0]      j_q, j_d, j_nxt;
  logic [KW-1:0]      k_q, k_d, k_nxt;
  logic               j_last, k_last;
  logic signed [35:0] acc_q, acc_d, acc_r12;
  logic signed [15:0] dv_q, dv_d, dout_q, dout_d, herr_q, herr_d, old_q, old_d;
  logic               out_valid_q, out_valid_d;
  mst_pkg::out_item_t out_q, out_d;

  logic signed [29:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [45:0] prod, prod_r12, prod_r24;
  mst_pkg::mem_req_t  mem_req;
  logic signed [15:0] rdata;
  logic               in_xfer;

  mst_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  mst_wmem u_wmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign j_last   = (j_q == JW'(HU - 1));
  assign k_last   = (k_q == KW'(NI - 1));
  assign j_nxt    = j_q + 1'b1;
  assign k_nxt    = k_q + 1'b1;
  assign acc_r12  = (acc_q + 36'sd2048) >>> 12;
  assign prod_r12 = (prod + 46'sd2048) >>> 12;
  assign prod_r24 = (prod + 46'sd8388608) >>> 24;
  assign err_new  = $signed({1'b0, t_q}) - $signed({1'b0, y_q});

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    x_d         = x_q;
    hid_d       = hid_q;
    wo_d        = wo_q;
    hd_d        = hd_q;
    t_d         = t_q;
    y_d         = y_q;
    sq_d        = sq_q;
    cor_d       = cor_q;
    err_d       = err_q;
    j_d         = j_q;
    k_d         = k_q;
    acc_d       = acc_q;
    dv_d        = dv_q;
    dout_d      = dout_q;
    herr_d      = herr_q;
    old_d       = old_q;
    lr_d        = lr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mul_a       = '0;
    mul_b       = '0;
    mem_req     = '0;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cfg_valid_i) lr_d = cfg_data_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d  = in_data_i.operation;
          y_d   = '0;
          sq_d  = '0;
          cor_d = 1'b0;
          unique case (in_data_i.operation)
            mst_pkg::OP_LOAD: begin
              if (int'(in_data_i.param_index) < mst_pkg::STORE_DEPTH) begin
                mem_req.we    = 1'b1;
                mem_req.addr  = AW'(in_data_i.param_index);
                mem_req.wdata = in_data_i.param_value;
              end
              state_d = S_OUT;
            end
            mst_pkg::OP_TRAIN, mst_pkg::OP_INFER: begin
              for (int k = 0; k < NI; k++) begin
                if (k == 0) x_d[k] = in_data_i.sample_x0;
                else if (k == 1) x_d[k] = in_data_i.sample_x1;
                else x_d[k] = '0;
              end
              t_d = (in_data_i.target > mst_pkg::Q_ONE) ? mst_pkg::Q_ONE : in_data_i.target;
              j_d = '0;
              mem_req.addr = AW'(mst_pkg::HBIAS_BASE);
              state_d = S_HBL;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_HBL: begin
        acc_d = $signed({{8{rdata[15]}}, rdata, 12'd0});
        k_d   = '0;
        mem_req.addr = AW'(int'(j_q));
        state_d = S_HM;
      end
      S_HM: begin
        mul_a   = 30'(x_q[k_q]);
        mul_b   = rdata;
        state_d = S_HA;
      end
      S_HA: begin
        acc_d = acc_q + $signed(prod[35:0]);
        if (k_last) begin
          state_d = S_HS;
        end else begin
          k_d = k_nxt;
          mem_req.addr = AW'(int'(k_nxt) * HU + int'(j_q));
          state_d = S_HM;
        end
      end
      S_HS: begin
        hid_d[j_q] = mst_pkg::sig_lookup(mst_pkg::sat16(48'(acc_r12)));
        if (j_last) begin
          mem_req.addr = AW'(mst_pkg::OBIAS_AT);
          state_d = S_OBL;
        end else begin
          j_d = j_nxt;
          mem_req.addr = AW'(mst_pkg::HBIAS_BASE + int'(j_nxt));
          state_d = S_HBL;
        end
      end
      S_OBL: begin
        acc_d = $signed({{8{rdata[15]}}, rdata, 12'd0});
        j_d   = '0;
        mem_req.addr = AW'(mst_pkg::OWEIGHT_BASE);
        state_d = S_OM;
      end
      S_OM: begin
        mul_a     = $signed(30'(hid_q[j_q]));
        mul_b     = rdata;
        wo_d[j_q] = rdata;
        state_d   = S_OA;
      end
      S_OA: begin
        acc_d = acc_q + $signed(prod[35:0]);
        if (j_last) begin
          state_d = S_OS;
        end else begin
          j_d = j_nxt;
          mem_req.addr = AW'(mst_pkg::OWEIGHT_BASE + int'(j_nxt));
          state_d = S_OM;
        end
      end
      S_OS: begin
        y_d     = mst_pkg::sig_lookup(mst_pkg::sat16(48'(acc_r12)));
        state_d = S_SQ;
      end
      S_SQ: begin
        err_d   = err_new;
        cor_d   = ((y_q >= mst_pkg::Q_HALF) == (t_q >= mst_pkg::Q_HALF));
        mul_a   = 30'(err_new);
        mul_b   = 16'(err_new);
        state_d = S_SQA;
      end
      S_SQA: begin
        sq_d    = (prod_r12 > 46'sd4096) ? mst_pkg::Q_ONE : prod_r12[12:0];
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!(out_valid_q && out_stall_i)) begin
          out_d.prediction    = y_q;
          out_d.squared_error = sq_q;
          out_d.correct       = cor_q;
          out_valid_d         = 1'b1;
          state_d = (op_q == mst_pkg::OP_TRAIN) ? S_DY : S_IDLE;
        end
      end
      S_DY: begin
        mul_a   = $signed(30'(y_q));
        mul_b   = $signed({3'b000, mst_pkg::Q_ONE - y_q});
        state_d = S_DYA;
      end
      S_DYA: begin
        dv_d    = prod_r12[15:0];
        state_d = S_DO;
      end
      S_DO: begin
        mul_a   = 30'(err_q);
        mul_b   = dv_q;
        state_d = S_DOA;
      end
      S_DOA: begin
        dout_d  = prod_r12[15:0];
        j_d     = '0;
        state_d = S_HD1;
      end
      S_HD1: begin
        mul_a   = $signed(30'(hid_q[j_q]));
        mul_b   = $signed({3'b000, mst_pkg::Q_ONE - hid_q[j_q]});
        state_d = S_HD2;
      end
      S_HD2: begin
        dv_d    = prod_r12[15:0];
        mul_a   = 30'(wo_q[j_q]);
        mul_b   = dout_q;
        state_d = S_HD3;
      end
      S_HD3: begin
        herr_d  = prod_r12[15:0];
        state_d = S_HD4;
      end
      S_HD4: begin
        mul_a   = 30'(herr_q);
        mul_b   = dv_q;
        state_d = S_HD5;
      end
      S_HD5: begin
        hd_d[j_q] = prod_r12[15:0];
        if (j_last) begin
          j_d = '0;
          k_d = '0;
          state_d = S_UW0;
        end else begin
          j_d = j_nxt;
          state_d = S_HD1;
        end
      end
      S_UW0: begin
        mem_req.addr = AW'(int'(k_q) * HU + int'(j_q));
        mul_a   = $signed(30'(lr_q));
        mul_b   = x_q[k_q];
        state_d = S_UW1;
      end
      S_UW1: begin
        old_d   = rdata;
        mul_a   = prod[29:0];
        mul_b   = hd_q[j_q];
        state_d = S_UW2;
      end
      S_UW2: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = AW'(int'(k_q) * HU + int'(j_q));
        mem_req.wdata = mst_pkg::sat16(48'(old_q) + 48'(prod_r24));
        if (k_last) begin
          state_d = S_UB0;
        end else begin
          k_d = k_nxt;
          state_d = S_UW0;
        end
      end
      S_UB0: begin
        mem_req.addr = AW'(mst_pkg::HBIAS_BASE + int'(j_q));
        mul_a   = $signed(30'(lr_q));
        mul_b   = hd_q[j_q];
        state_d = S_UB1;
      end
      S_UB1: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = AW'(mst_pkg::HBIAS_BASE + int'(j_q));
        mem_req.wdata = mst_pkg::sat16(48'(rdata) + 48'(prod_r12));
        k_d = '0;
        if (j_last) begin
          j_d = '0;
          state_d = S_VW0;
        end else begin
          j_d = j_nxt;
          state_d = S_UW0;
        end
      end
      S_VW0: begin
        mem_req.addr = AW'(mst_pkg::OWEIGHT_BASE + int'(j_q));
        mul_a   = $signed(30'(lr_q));
        mul_b   = $signed(16'(hid_q[j_q]));
        state_d = S_VW1;
      end
      S_VW1: begin
        old_d   = rdata;
        mul_a   = prod[29:0];
        mul_b   = dout_q;
        state_d = S_VW2;
      end
      S_VW2: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = AW'(mst_pkg::OWEIGHT_BASE + int'(j_q));
        mem_req.wdata = mst_pkg::sat16(48'(old_q) + 48'(prod_r24));
        if (j_last) begin
          state_d = S_VB0;
        end else begin
          j_d = j_nxt;
          state_d = S_VW0;
        end
      end
      S_VB0: begin
        mem_req.addr = AW'(mst_pkg::OBIAS_AT);
        mul_a   = $signed(30'(lr_q));
        mul_b   = dout_q;
        state_d = S_VB1;
      end
      S_VB1: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = AW'(mst_pkg::OBIAS_AT);
        mem_req.wdata = mst_pkg::sat16(48'(rdata) + 48'(prod_r12));
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      lr_q        <= mst_pkg::LR_RESET;
      op_q        <= mst_pkg::OP_LOAD;
      j_q         <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      lr_q        <= lr_d;
      op_q        <= op_d;
      j_q         <= j_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    hid_q  <= hid_d;
    wo_q   <= wo_d;
    hd_q   <= hd_d;
    t_q    <= t_d;
    y_q    <= y_d;
    sq_q   <= sq_d;
    cor_q  <= cor_d;
    err_q  <= err_d;
    acc_q  <= acc_d;
    dv_q   <= dv_d;
    dout_q <= dout_d;
    herr_q <= herr_d;
    old_q  <= old_d;
    out_q  <= out_d;
  end

endmodule
